// File: rtl/core/rlcb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlcb_pkg
// Shared types and command codes of the raster drawing engine.
// ----------------------------------------------------------------------------
package rlcb_pkg;

  localparam logic [2:0] REQ_POINT   = 3'd0;
  localparam logic [2:0] REQ_LINE    = 3'd1;
  localparam logic [2:0] REQ_BOX     = 3'd2;
  localparam logic [2:0] REQ_OUTLINE = 3'd3;
  localparam logic [2:0] REQ_CIRCLE  = 3'd4;
  localparam logic [2:0] REQ_READ    = 3'd5;

  localparam int unsigned ROW_BYTES  = 32;
  localparam int unsigned ADDR_BITS  = 13;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  x0;
    logic [7:0]  y0;
    logic [7:0]  x1;
    logic [7:0]  y1;
    logic [7:0]  radius;
    logic [12:0] read_address;
  } rlcb_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       is_read_reply;
  } rlcb_rsp_t;

  // One pixel offered by the shape walker.
  typedef struct packed {
    logic       valid;
    logic [7:0] x;
    logic [7:0] y;
  } rlcb_pix_t;

endpackage

// File: rtl/core/rlcb_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlcb_store
// Byte-wide frame store with a registered read and a clearing pass after reset.
// ----------------------------------------------------------------------------
module rlcb_store #(
  parameter int unsigned DEPTH = 6144,
  parameter int unsigned AW    = 13
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  output logic          clearing
);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= 8'h00;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/rlcb_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlcb_walker
// Sequencer that walks a point, line, box or circle one pixel at a time.
// ----------------------------------------------------------------------------
module rlcb_walker
  import rlcb_pkg::*;
#(
  parameter int unsigned VISIBLE_ROWS = 192
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  rlcb_req_t cmd,
  output rlcb_pix_t pix,
  input  logic      pix_ready,
  output logic      busy
);

  localparam logic [2:0] W_IDLE  = 3'd0;
  localparam logic [2:0] W_POINT = 3'd1;
  localparam logic [2:0] W_LINE  = 3'd2;
  localparam logic [2:0] W_BOX   = 3'd3;
  localparam logic [2:0] W_CIRC  = 3'd4;
  localparam logic [7:0] YMAX    = 8'(VISIBLE_ROWS - 1);

  logic [2:0] state;
  logic [7:0] px, py, ex, ey, x_lo;
  logic [7:0] dx, dy;
  logic       sx, sy, major_x;
  logic [9:0] acc;
  logic [7:0] ox0, oy0, ox1, oy1;
  logic [1:0] phase;
  logic       outline;
  logic [7:0] cx, cy, ca, cb;
  logic signed [11:0] f;
  logic [2:0] k;

  // Box corner selection and ordering.
  logic [1:0] lp;
  logic [7:0] bax, bay, bbx, bby, blx, bhx, bly, bhy;
  logic [9:0] acc_sum;
  logic [7:0] u, v, cxn, cyn, ca_n;
  logic [8:0] cb_n;
  logic signed [11:0] f_a, f_n;

  always_comb begin
    lp = start ? 2'd0 : phase + 2'd1;
    bax = ox0; bay = oy0; bbx = ox1; bby = oy1;
    if (start && cmd.req_type == REQ_BOX) begin
      bax = cmd.x0; bay = cmd.y0; bbx = cmd.x1; bby = cmd.y1;
    end else begin
      case (lp)
        2'd0: begin bax = ox0; bay = oy0; bbx = ox1; bby = oy0; end
        2'd1: begin bax = ox0; bay = oy1; bbx = ox1; bby = oy1; end
        2'd2: begin bax = ox0; bay = oy0; bbx = ox0; bby = oy1; end
        default: begin bax = ox1; bay = oy0; bbx = ox1; bby = oy1; end
      endcase
      if (start) begin
        bax = cmd.x0;
        bbx = cmd.x1;
        bay = cmd.y0;
        bby = cmd.y0;
      end
    end
    blx = (bax > bbx) ? bbx : bax;
    bhx = (bax > bbx) ? bax : bbx;
    bly = (bay > bby) ? bby : bay;
    bhy = (bay > bby) ? bay : bby;
    if (bly > YMAX) bly = YMAX;
    if (bhy > YMAX) bhy = YMAX;
  end

  // Circle octant point and decision update.
  always_comb begin
    u   = k[2] ? cb : ca;
    v   = k[2] ? ca : cb;
    cxn = k[0] ? cx - u : cx + u;
    cyn = k[1] ? cy - v : cy + v;
    ca_n = (f >= 0) ? ca - 8'd1 : ca;
    f_a  = (f >= 0) ? f - $signed({2'b00, ca_n, 2'b00}) : f;
    cb_n = {1'b0, cb} + 9'd1;
    f_n  = f_a + $signed({1'b0, cb_n, 2'b10});
    acc_sum = acc + {2'b00, (major_x ? dy : dx)};
  end

  always_comb begin
    pix.valid = (state != W_IDLE);
    pix.x = (state == W_CIRC) ? cxn : px;
    pix.y = (state == W_CIRC) ? cyn : py;
  end

  assign busy = (state != W_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= W_IDLE;
    end else if (start) begin
      phase   <= 2'd0;
      case (cmd.req_type)
        REQ_POINT: begin
          state <= W_POINT;
          px <= cmd.x0;
          py <= cmd.y0;
        end
        REQ_LINE: begin
          state <= W_LINE;
          px <= cmd.x0;
          py <= cmd.y0;
          ex <= cmd.x1;
          ey <= cmd.y1;
          sx <= cmd.x0 < cmd.x1;
          sy <= cmd.y0 < cmd.y1;
          dx <= (cmd.x0 < cmd.x1) ? cmd.x1 - cmd.x0 : cmd.x0 - cmd.x1;
          dy <= (cmd.y0 < cmd.y1) ? cmd.y1 - cmd.y0 : cmd.y0 - cmd.y1;
          if (((cmd.x0 < cmd.x1) ? cmd.x1 - cmd.x0 : cmd.x0 - cmd.x1) >
              ((cmd.y0 < cmd.y1) ? cmd.y1 - cmd.y0 : cmd.y0 - cmd.y1)) begin
            major_x <= 1'b1;
            acc <= {2'b00, ((cmd.x0 < cmd.x1) ? cmd.x1 - cmd.x0 : cmd.x0 - cmd.x1) >> 1};
          end else begin
            major_x <= 1'b0;
            acc <= {2'b00, ((cmd.y0 < cmd.y1) ? cmd.y1 - cmd.y0 : cmd.y0 - cmd.y1) >> 1};
          end
        end
        REQ_BOX, REQ_OUTLINE: begin
          state   <= W_BOX;
          outline <= (cmd.req_type == REQ_OUTLINE);
          ox0 <= cmd.x0;
          oy0 <= cmd.y0;
          ox1 <= cmd.x1;
          oy1 <= cmd.y1;
          px <= blx; x_lo <= blx; ex <= bhx;
          py <= bly; ey <= bhy;
        end
        REQ_CIRCLE: begin
          if (cmd.radius != 8'd0) begin
            state <= W_CIRC;
          end
          cx <= cmd.x0;
          cy <= cmd.y0;
          ca <= cmd.radius;
          cb <= 8'd0;
          k  <= 3'd0;
          f  <= 12'sd3 - $signed({3'b000, cmd.radius, 1'b0});
        end
        default: state <= W_IDLE;
      endcase
    end else if (pix_ready && busy) begin
      case (state)
        W_POINT: state <= W_IDLE;
        W_LINE: begin
          if (major_x) begin
            if (acc_sum >= {2'b00, dx}) begin
              acc <= acc_sum - {2'b00, dx};
              py  <= sy ? py + 8'd1 : py - 8'd1;
            end else begin
              acc <= acc_sum;
            end
            if (px == ex) state <= W_IDLE;
            else px <= sx ? px + 8'd1 : px - 8'd1;
          end else begin
            if (acc_sum >= {2'b00, dy}) begin
              acc <= acc_sum - {2'b00, dy};
              px  <= sx ? px + 8'd1 : px - 8'd1;
            end else begin
              acc <= acc_sum;
            end
            if (py == ey) state <= W_IDLE;
            else py <= sy ? py + 8'd1 : py - 8'd1;
          end
        end
        W_BOX: begin
          if (px == ex) begin
            if (py == ey) begin
              if (outline && phase != 2'd3) begin
                phase <= lp;
                px <= blx; x_lo <= blx; ex <= bhx;
                py <= bly; ey <= bhy;
              end else begin
                state <= W_IDLE;
              end
            end else begin
              px <= x_lo;
              py <= py + 8'd1;
            end
          end else begin
            px <= px + 8'd1;
          end
        end
        W_CIRC: begin
          k <= k + 3'd1;
          if (k == 3'd7) begin
            ca <= ca_n;
            cb <= cb_n[7:0];
            f  <= f_n;
            if ({1'b0, ca_n} < cb_n) state <= W_IDLE;
          end
        end
        default: state <= W_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/raster_line_circle_box_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raster_line_circle_box_engine
// 2D drawing engine over a one-bit-per-pixel frame store, 256 pixels wide.
// ----------------------------------------------------------------------------
// One item at a time. Each drawn pixel costs a read-modify-write of its
// store byte, the pixel set or cleared by the draw color; pixels on rows
// at or beyond VISIBLE_ROWS are skipped with no store access. After reset
// the store is cleared, during which no item is taken.
module raster_line_circle_box_engine
  import rlcb_pkg::*;
#(
  parameter int unsigned VISIBLE_ROWS = 192
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  rlcb_req_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rlcb_rsp_t rsp,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  localparam int unsigned DEPTH = VISIBLE_ROWS * ROW_BYTES;
  localparam int unsigned AW    = $clog2(DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WALK = 3'd1;
  localparam logic [2:0] S_PXWR = 3'd2;
  localparam logic [2:0] S_RDW  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]  state;
  logic        draw_color;
  logic        accept;
  logic        start;
  logic        busy;
  logic        clearing;
  logic        pix_ready;
  logic        skip;
  logic        in_range;
  logic        rd_en, wr_en;
  logic [AW-1:0] rd_addr, pix_addr;
  logic [7:0]  rd_data, wr_data, mask;
  logic [7:0]  res_data;
  logic        res_is;
  rlcb_pix_t   pix;
  logic [12:0] pix_full;

  assign req_ready = (state == S_IDLE) && !clearing;
  assign accept    = req_valid && req_ready;
  assign start     = accept && (req.req_type != REQ_READ);

  assign skip     = ({1'b0, pix.y} >= 9'(VISIBLE_ROWS));
  assign pix_full = {pix.y, pix.x[7:3]};
  assign pix_addr = pix_full[AW-1:0];
  assign mask     = 8'h80 >> pix.x[2:0];
  assign wr_data  = draw_color ? (rd_data | mask) : (rd_data & ~mask);

  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = pix_addr;
    wr_en     = 1'b0;
    pix_ready = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept && req.req_type == REQ_READ) begin
          rd_en   = 1'b1;
          rd_addr = req.read_address[AW-1:0];
        end
      end
      S_WALK: begin
        if (pix.valid) begin
          if (skip) pix_ready = 1'b1;
          else rd_en = 1'b1;
        end
      end
      S_PXWR: begin
        wr_en     = 1'b1;
        pix_ready = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      draw_color <= 1'b0;
    end else if (cfg_we) begin
      draw_color <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && state != S_FIN) rsp_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_data <= 8'h00;
            res_is   <= (req.req_type == REQ_READ);
            in_range <= ({1'b0, req.read_address} < 14'(DEPTH));
            state    <= (req.req_type == REQ_READ) ? S_RDW : S_WALK;
          end
        end
        S_WALK: begin
          if (!busy) state <= S_FIN;
          else if (pix.valid && !skip) state <= S_PXWR;
        end
        S_PXWR: state <= S_WALK;
        S_RDW: begin
          res_data <= in_range ? rd_data : 8'h00;
          state    <= S_FIN;
        end
        S_FIN: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid         <= 1'b1;
            rsp.read_data     <= res_data;
            rsp.is_read_reply <= res_is;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  rlcb_walker #(
    .VISIBLE_ROWS(VISIBLE_ROWS)
  ) u_walker (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .cmd      (req),
    .pix      (pix),
    .pix_ready(pix_ready),
    .busy     (busy)
  );

  rlcb_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (pix_addr),
    .wr_data (wr_data),
    .clearing(clearing)
  );

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the raster drawing engine with directed and random commands (points,
// lines, boxes, outlines, circles, byte reads, unknown codes) under varying
// handshake idling. A local pixel store model predicts every reply, which is
// checked field by field.
// ----------------------------------------------------------------------------
module testbench;
  import rlcb_pkg::*;

  localparam int unsigned ROWS        = 192;
  localparam int unsigned STORE_SIZE  = ROWS * ROW_BYTES;
  localparam int unsigned STALL_LIMIT = 400000;
  localparam int unsigned REQ_W       = $bits(rlcb_req_t);
  localparam logic [2:0]  REQ_BAD6    = 3'd6;
  localparam logic [2:0]  REQ_BAD7    = 3'd7;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  rlcb_req_t req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  rlcb_rsp_t rsp;
  logic      cfg_we = 1'b0;
  logic      cfg_wdata = 1'b0;

  raster_line_circle_box_engine #(.VISIBLE_ROWS(ROWS)) u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  logic [7:0] pixels [STORE_SIZE];
  logic       ink;
  rlcb_rsp_t  pending_replies [$];
  int         send_idle_pct;
  int         recv_idle_pct;
  int         mismatches;
  int         items_sent;
  int         reads_sent;
  int         replies_seen;
  int         quiet_cycles;
  logic [7:0] last_x;
  logic [7:0] last_y;

  function automatic void plot(input int unsigned px, input int unsigned py);
    int unsigned a;
    logic [7:0]  m;
    px = px & 255;
    py = py & 255;
    if (py >= ROWS) return;
    a = py * ROW_BYTES + (px >> 3);
    m = 8'h80 >> (px & 7);
    if (ink) pixels[a] = pixels[a] | m;
    else pixels[a] = pixels[a] & ~m;
  endfunction

  function automatic void trace_line(input int unsigned ax, input int unsigned ay,
                                     input int unsigned bx, input int unsigned by);
    int unsigned x, y, dx, dy, sx, sy;
    int acc;
    x = ax;
    y = ay;
    if (ax < bx) begin dx = bx - ax; sx = 1; end
    else begin dx = ax - bx; sx = 255; end
    if (ay < by) begin dy = by - ay; sy = 1; end
    else begin dy = ay - by; sy = 255; end
    if (dx > dy) begin
      acc = dx >> 1;
      forever begin
        plot(x, y);
        acc += dy;
        if (acc >= int'(dx)) begin
          acc -= dx;
          y = (y + sy) & 255;
        end
        if (x == bx) return;
        x = (x + sx) & 255;
      end
    end else begin
      acc = dy >> 1;
      forever begin
        plot(x, y);
        acc += dx;
        if (acc >= int'(dy)) begin
          acc -= dy;
          x = (x + sx) & 255;
        end
        if (y == by) return;
        y = (y + sy) & 255;
      end
    end
  endfunction

  function automatic void paint_box(input int unsigned ax, input int unsigned ay,
                                    input int unsigned bx, input int unsigned by);
    int unsigned t;
    if (ax > bx) begin t = ax; ax = bx; bx = t; end
    if (ay > by) begin t = ay; ay = by; by = t; end
    if (ay > ROWS - 1) ay = ROWS - 1;
    if (by > ROWS - 1) by = ROWS - 1;
    for (int unsigned y = ay; y <= by; y++)
      for (int unsigned x = ax; x <= bx; x++)
        plot(x, y);
  endfunction

  function automatic void trace_circle(input int unsigned cx, input int unsigned cy,
                                       input int unsigned r);
    int unsigned x, y;
    int f;
    if (r == 0) return;
    x = r;
    y = 0;
    f = 3 - 2 * int'(r);
    while (x >= y) begin
      plot(cx + x, cy + y);
      plot(cx - x, cy + y);
      plot(cx + x, cy - y);
      plot(cx - x, cy - y);
      plot(cx + y, cy + x);
      plot(cx - y, cy + x);
      plot(cx + y, cy - x);
      plot(cx - y, cy - x);
      if (f >= 0) begin
        x--;
        f -= int'(x << 2);
      end
      y++;
      f += int'(y << 2) + 2;
    end
  endfunction

  // Applies one command to the pixel store and returns the reply it earns.
  function automatic rlcb_rsp_t draw_command(input rlcb_req_t r);
    rlcb_rsp_t o;
    o = '0;
    case (r.req_type)
      REQ_POINT:   plot(r.x0, r.y0);
      REQ_LINE:    trace_line(r.x0, r.y0, r.x1, r.y1);
      REQ_BOX:     paint_box(r.x0, r.y0, r.x1, r.y1);
      REQ_OUTLINE: begin
        paint_box(r.x0, r.y0, r.x1, r.y0);
        paint_box(r.x0, r.y1, r.x1, r.y1);
        paint_box(r.x0, r.y0, r.x0, r.y1);
        paint_box(r.x1, r.y0, r.x1, r.y1);
      end
      REQ_CIRCLE:  trace_circle(r.x0, r.y0, r.radius);
      REQ_READ: begin
        if (r.read_address < STORE_SIZE) o.read_data = pixels[r.read_address];
        o.is_read_reply = 1'b1;
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic send_item(input rlcb_req_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      req <= rlcb_req_t'(REQ_W'({$urandom, $urandom}));
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    pending_replies.push_back(draw_command(r));
    items_sent++;
    if (r.req_type == REQ_READ) reads_sent++;
  endtask

  task automatic drain_and_set_color(input logic c);
    req_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    ink = c;
  endtask

  function automatic rlcb_req_t make_cmd(input logic [2:0] op, input int x0, input int y0,
                                         input int x1, input int y1, input int rad,
                                         input int addr);
    rlcb_req_t r;
    r.req_type = op;
    r.x0 = 8'(x0);
    r.y0 = 8'(y0);
    r.x1 = 8'(x1);
    r.y1 = 8'(y1);
    r.radius = 8'(rad);
    r.read_address = 13'(addr);
    return r;
  endfunction

  task automatic read_at(input int unsigned x, input int unsigned y);
    send_item(make_cmd(REQ_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
                       y * ROW_BYTES + (x >> 3)));
  endtask

  task automatic test_directed();
    drain_and_set_color(1'b1);
    send_item(make_cmd(REQ_POINT, 0, 0, 0, 0, 0, 0));
    read_at(0, 0);
    send_item(make_cmd(REQ_POINT, 255, 255, 0, 0, 0, 0));
    send_item(make_cmd(REQ_POINT, 7, 191, 0, 0, 0, 0));
    read_at(7, 191);
    send_item(make_cmd(REQ_LINE, 250, 10, 3, 40, 0, 0));
    send_item(make_cmd(REQ_LINE, 20, 180, 25, 0, 0, 0));
    read_at(20, 180);
    // A box whose rows both lie below the screen still lands on the last row.
    send_item(make_cmd(REQ_BOX, 100, 250, 90, 200, 0, 0));
    read_at(96, 191);
    send_item(make_cmd(REQ_OUTLINE, 200, 5, 180, 30, 0, 0));
    read_at(184, 5);
    send_item(make_cmd(REQ_CIRCLE, 60, 60, 0, 0, 0, 0));
    read_at(60, 60);
    // Circle around a corner wraps on both axes.
    send_item(make_cmd(REQ_CIRCLE, 2, 3, 0, 0, 10, 0));
    read_at(248, 3);
    send_item(make_cmd(REQ_READ, 0, 0, 0, 0, 0, STORE_SIZE - 1));
    send_item(make_cmd(REQ_READ, 255, 255, 255, 255, 255, 8191));
    send_item(make_cmd(REQ_BAD6, 1, 1, 1, 1, 1, 0));
    send_item(make_cmd(REQ_BAD7, 255, 255, 255, 255, 255, 8191));
    drain_and_set_color(1'b0);
    send_item(make_cmd(REQ_BOX, 0, 0, 255, 191, 0, 0));
    read_at(0, 0);
    read_at(255, 191);
  endtask

  task automatic test_random(input int count);
    rlcb_req_t r;
    int        pick;
    int        w, h;
    for (int i = 0; i < count; i++) begin
      r = rlcb_req_t'(REQ_W'({$urandom, $urandom}));
      pick = $urandom_range(99);
      if (pick < 15) r.req_type = REQ_POINT;
      else if (pick < 30) r.req_type = REQ_LINE;
      else if (pick < 40) r.req_type = REQ_BOX;
      else if (pick < 48) r.req_type = REQ_OUTLINE;
      else if (pick < 58) r.req_type = REQ_CIRCLE;
      else if (pick < 96) r.req_type = REQ_READ;
      else r.req_type = ($urandom_range(1)) ? REQ_BAD6 : REQ_BAD7;
      if (r.req_type == REQ_BOX || r.req_type == REQ_OUTLINE) begin
        // Mostly small boxes; an unconstrained one now and then.
        if ($urandom_range(49) != 0) begin
          w = $urandom_range(15);
          h = $urandom_range(15);
          r.x1 = 8'(r.x0 + (($urandom_range(1)) ? w : -w));
          r.y1 = 8'(r.y0 + (($urandom_range(1)) ? h : -h));
          if (r.x0 < r.x1 && r.x1 - r.x0 > 15) r.x1 = r.x0;
          if (r.x1 < r.x0 && r.x0 - r.x1 > 15) r.x1 = r.x0;
        end
      end
      if (r.req_type == REQ_CIRCLE && $urandom_range(3) != 0)
        r.radius = 8'($urandom_range(40));
      if (r.req_type == REQ_READ) begin
        if ($urandom_range(9) == 0) r.read_address = 13'($urandom_range(8191));
        else r.read_address = 13'((last_y % ROWS) * ROW_BYTES + (last_x >> 3));
      end else begin
        last_x = r.x0;
        last_y = r.y0;
      end
      send_item(r);
    end
  endtask

  always @(posedge clk) begin
    rlcb_rsp_t want;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d idle cycles", quiet_cycles);
        $display("raster_line_circle_box_engine: mismatch");
        $finish;
      end
      if (rsp_valid && rsp_ready) begin
        replies_seen++;
        if (pending_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected reply %p", rsp);
        end else begin
          want = pending_replies.pop_front();
          if (rsp.read_data !== want.read_data || rsp.is_read_reply !== want.is_read_reply) begin
            mismatches++;
            if (mismatches <= 10)
              $display("reply %0d: expected data %h flag %b, got data %h flag %b",
                       replies_seen, want.read_data, want.is_read_reply,
                       rsp.read_data, rsp.is_read_reply);
          end
        end
      end
    end
  end

  initial begin
    ink = 1'b0;
    mismatches = 0;
    items_sent = 0;
    reads_sent = 0;
    replies_seen = 0;
    last_x = 0;
    last_y = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    foreach (pixels[i]) pixels[i] = 8'h00;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 34;
    recv_idle_pct = 53;
    test_directed();
    drain_and_set_color(1'b1);
    test_random(400);
    send_idle_pct = 53;
    recv_idle_pct = 34;
    drain_and_set_color(1'b0);
    test_random(150);
    drain_and_set_color(1'b1);
    test_random(250);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain_and_set_color(1'b0);
    test_random(100);
    drain_and_set_color(1'b1);
    test_random(200);
    req_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d commands (%0d byte reads) and %0d replies over both colors",
             items_sent, reads_sent, replies_seen);
    if (mismatches == 0) begin
      $display("raster_line_circle_box_engine: match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("raster_line_circle_box_engine: mismatch");
    end
    $finish;
  end

endmodule
